/* rtl/core/wbss_pkg.sv */
package wbss_pkg;

   localparam int PATTERN_MAX   = 32;
   localparam int POSITION_BITS = 32;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 64;
   localparam int ADDR_W        = 64;
   localparam int CARE_W        = 32;
   localparam int LEN_W         = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int PAT_WORDS     = 4;
   localparam int BYTES_PER_WORD = WORD_W / BYTE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0_7   = 3'd0,
      CSR_PATTERN_8_15  = 3'd1,
      CSR_PATTERN_16_23 = 3'd2,
      CSR_PATTERN_24_31 = 3'd3,
      CSR_CARE_MASK     = 3'd4,
      CSR_PATTERN_LEN   = 3'd5,
      CSR_REGION_BASE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
      logic [PATTERN_MAX-1:0]             care;
      logic [LEN_W-1:0]                   len;
      logic [ADDR_W-1:0]                  base;
   } match_cfg_type;

endpackage

/* rtl/core/wbss_if.sv */
interface wbss_req_if;
   import wbss_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_region;
   modport source (output valid, output data_byte, output end_of_region, input ready);
   modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface wbss_rsp_if;
   import wbss_pkg::*;
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;
   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

interface wbss_csr_if;
   import wbss_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/wbss_cell.sv */
module wbss_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [wbss_pkg::BYTE_W-1:0] byte_in,
   input  logic [wbss_pkg::BYTE_W-1:0] pat_byte,
   input  logic                        care_bit,
   output logic [wbss_pkg::BYTE_W-1:0] byte_out,
   output logic                        hit
);
   import wbss_pkg::*;

   logic [BYTE_W-1:0] window_ff;
   logic [BYTE_W-1:0] window_in;

   assign window_in = shift ? byte_in : window_ff;
   assign byte_out  = window_ff;
   assign hit       = !care_bit || (byte_in == pat_byte);

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

/* rtl/core/wbss_csr.sv */
module wbss_csr (
   input  logic                    clock,
   input  logic                    reset,
   wbss_csr_if.sink                csr_if,
   output wbss_pkg::match_cfg_type cfg,
   output logic                    settle
);
   import wbss_pkg::*;

   logic [PAT_WORDS-1:0][WORD_W-1:0]   pat_ff;
   logic [CARE_W-1:0]                  care_ff;
   logic [LEN_W-1:0]                   len_ff;
   logic [ADDR_W-1:0]                  base_ff;
   logic                               settle_ff;
   match_cfg_type                      cfg_ff;
   match_cfg_type                      cfg_in;
   logic [LEN_W-1:0]                   len_clamp;
   logic [LEN_W-1:0]                   shamt;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] rev_pat;
   logic [PATTERN_MAX-1:0]             rev_care;
   logic                               write_fire;

   assign csr_if.ready = 1'b1;
   assign write_fire   = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff    <= '0;
         care_ff   <= '1;
         len_ff    <= LEN_W'(1);
         base_ff   <= '0;
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= write_fire;
         if (write_fire) begin
            case (csr_index_type'(csr_if.index))
               CSR_PATTERN_0_7:   pat_ff[0] <= csr_if.data;
               CSR_PATTERN_8_15:  pat_ff[1] <= csr_if.data;
               CSR_PATTERN_16_23: pat_ff[2] <= csr_if.data;
               CSR_PATTERN_24_31: pat_ff[3] <= csr_if.data;
               CSR_CARE_MASK:     care_ff   <= csr_if.data[CARE_W-1:0];
               CSR_PATTERN_LEN:   len_ff    <= csr_if.data[LEN_W-1:0];
               CSR_REGION_BASE:   base_ff   <= csr_if.data;
               default: ;
            endcase
         end
      end
   end

   // Cell k compares its byte with pattern byte length-1-k, so the pattern is
   // reversed and shifted down by the unused part of the window.
   always_comb begin
      len_clamp = (len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_ff;
      shamt     = LEN_W'(PATTERN_MAX) - len_clamp;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         rev_pat[j]  = pat_ff[(PATTERN_MAX-1-j) / BYTES_PER_WORD]
                       [((PATTERN_MAX-1-j) % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
         rev_care[j] = care_ff[PATTERN_MAX-1-j];
      end
      cfg_in.pat  = rev_pat >> {shamt, 3'b000};
      cfg_in.care = rev_care >> shamt;
      cfg_in.len  = len_clamp;
      cfg_in.base = base_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg    = cfg_ff;
   assign settle = settle_ff;

endmodule

/* rtl/core/wildcard_byte_signature_scan_core.sv */
// Scans a region one byte per cycle and reports the first position where the
// last pattern_length bytes equal the configured pattern, bytes whose care bit
// is clear matching anything. Each byte is taken in one transfer; a region
// gives exactly one result, registered and carried in the cycle after the
// transfer of the byte that completes the match or of the final byte. The
// byte window is a row of 32 compare cells fed by a shift chain. Throughput
// is one byte per cycle; req ready drops while a result waits and the result
// side is not ready (the next byte is taken in the cycle that the waiting
// result is transferred), in the cycle after each register write while the
// aligned pattern is reloaded, and while the reload flag is still set by reset.
module wildcard_byte_signature_scan_core (
   input  logic        clock,
   input  logic        reset,
   wbss_req_if.sink    req_if,
   wbss_rsp_if.source  rsp_if,
   wbss_csr_if.sink    csr_if
);
   import wbss_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   match_cfg_type            cfg;
   logic                     settle;
   logic [BYTE_W-1:0]        window [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]   hits;
   logic                     req_fire;
   logic                     active;
   logic                     match_now;
   logic [POSITION_BITS-1:0] pos_next;
   logic [POSITION_BITS-1:0] offset;
   logic [ADDR_W-1:0]        address;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     reported_ff, reported_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;

   wbss_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg),
      .settle (settle)
   );

   assign req_if.ready = !settle && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire     = req_if.valid && req_if.ready;
   assign active       = req_fire && !reported_ff;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      wbss_cell u_cell (
         .clock    (clock),
         .shift    (active),
         .byte_in  ((k == 0) ? req_if.data_byte : window[(k == 0) ? 0 : k-1]),
         .pat_byte (cfg.pat[k]),
         .care_bit (cfg.care[k]),
         .byte_out (window[k]),
         .hit      (hits[k])
      );
   end

   always_comb begin
      pos_next  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_BITS'(1);
      match_now = (cfg.len != '0) && (pos_next >= POSITION_BITS'(cfg.len)) && (&hits);
      offset    = pos_next - POSITION_BITS'(cfg.len);
      address   = cfg.base + ADDR_W'(offset);
   end

   always_comb begin
      pos_in       = pos_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      found_in     = found_ff;
      addr_in      = addr_ff;
      if (active) begin
         pos_in = pos_next;
         if (match_now) begin
            reported_in  = 1'b1;
            rsp_valid_in = 1'b1;
            found_in     = 1'b1;
            addr_in      = address;
         end else if (req_if.end_of_region) begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b0;
            addr_in      = '0;
         end
      end
      if (req_fire && req_if.end_of_region) begin
         pos_in      = '0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.found         = found_ff;
   assign rsp_if.match_address = addr_ff;

   a_settle_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_if.valid && csr_if.ready) |=> !req_if.ready)
      else $error("Byte accepted before the aligned pattern was reloaded.");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (addr_ff == '0))
      else $error("Not-found result carries a nonzero address.");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("Result raised without a byte transfer.");

   a_region_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.end_of_region) |=> (pos_ff == '0 && !reported_ff))
      else $error("Region state not cleared after the final byte.");

endmodule
